FILE: hw/rtl/ccn_pkg.sv
// ----------------------------------------------------------------------------
// Color channel normalizer package
// Shared widths, register indexes, the configuration bundle and the
// response bundle of the scaling unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ccn_pkg;

    localparam int RAW_BITS       = 16;
    localparam int OUT_BITS       = 8;
    localparam int GAIN_BITS      = 8;
    localparam int LIMIT_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int NUM_CH         = 3;
    localparam int CH_BITS        = 2;

    localparam logic [OUT_BITS-1:0]   SAT_MAX           = 8'd255;
    localparam logic [GAIN_BITS-1:0]  MAX_GAIN_RESET    = 8'd10;
    localparam logic [LIMIT_BITS-1:0] OUTLIER_RESET     = 8'd30;
    localparam logic [CH_BITS-1:0]    CH_FIRST          = 2'd0;
    localparam logic [CH_BITS-1:0]    CH_LAST           = 2'd2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DARK_THRESHOLD = 3'd0,
        REG_BLACK_RED      = 3'd1,
        REG_BLACK_GREEN    = 3'd2,
        REG_BLACK_BLUE     = 3'd3,
        REG_MAX_GAIN       = 3'd4,
        REG_OUTLIER_LIMIT  = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [RAW_BITS-1:0]   dark_threshold;
        logic [RAW_BITS-1:0]   black_red_offset;
        logic [RAW_BITS-1:0]   black_green_offset;
        logic [RAW_BITS-1:0]   black_blue_offset;
        logic [GAIN_BITS-1:0]  max_gain;
        logic [LIMIT_BITS-1:0] outlier_limit;
    } cfg_t;

    typedef struct packed {
        logic                done;
        logic [OUT_BITS-1:0] value;
    } scale_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ccn_if.sv
// ----------------------------------------------------------------------------
// Color channel normalizer stream interfaces
// Valid/ready channels for the raw sample word and the color result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccn_in_if;
    logic                          valid;
    logic                          ready;
    logic [ccn_pkg::RAW_BITS-1:0]  red_raw;
    logic [ccn_pkg::RAW_BITS-1:0]  green_raw;
    logic [ccn_pkg::RAW_BITS-1:0]  blue_raw;
    logic [ccn_pkg::RAW_BITS-1:0]  clear_raw;

    modport source (output valid, output red_raw, output green_raw,
                    output blue_raw, output clear_raw, input ready);
    modport sink   (input valid, input red_raw, input green_raw,
                    input blue_raw, input clear_raw, output ready);
endinterface

interface ccn_out_if;
    logic                          valid;
    logic                          ready;
    logic [ccn_pkg::OUT_BITS-1:0]  red_out;
    logic [ccn_pkg::OUT_BITS-1:0]  green_out;
    logic [ccn_pkg::OUT_BITS-1:0]  blue_out;
    logic                          is_dark;

    modport source (output valid, output red_out, output green_out,
                    output blue_out, output is_dark, input ready);
    modport sink   (input valid, input red_out, input green_out,
                    input blue_out, input is_dark, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/ccn_cfg_regs.sv
// ----------------------------------------------------------------------------
// Color channel normalizer configuration registers
// Write-only register file; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ccn_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                we,
    input  wire logic [ccn_pkg::CFG_INDEX_BITS-1:0]  index,
    input  wire logic [ccn_pkg::CFG_DATA_BITS-1:0]   data,
    output ccn_pkg::cfg_t                            cfg
);
    import ccn_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            case (index)
                REG_DARK_THRESHOLD: cfg_next.dark_threshold     = data;
                REG_BLACK_RED:      cfg_next.black_red_offset   = data;
                REG_BLACK_GREEN:    cfg_next.black_green_offset = data;
                REG_BLACK_BLUE:     cfg_next.black_blue_offset  = data;
                REG_MAX_GAIN:       cfg_next.max_gain      = data[GAIN_BITS-1:0];
                REG_OUTLIER_LIMIT:  cfg_next.outlier_limit = data[LIMIT_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_threshold     <= '0;
            cfg_reg.black_red_offset   <= '0;
            cfg_reg.black_green_offset <= '0;
            cfg_reg.black_blue_offset  <= '0;
            cfg_reg.max_gain           <= MAX_GAIN_RESET;
            cfg_reg.outlier_limit      <= OUTLIER_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ccn_scale_unit.sv
// ----------------------------------------------------------------------------
// Color channel normalizer scaling unit
// Scales one channel by 255/clear, capped by the gain limit and saturated
// at 255, using one multiplier and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module ccn_scale_unit #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [COUNT_BITS-1:0]           raw,
    input  wire logic [COUNT_BITS-1:0]           clear,
    input  wire logic [ccn_pkg::GAIN_BITS-1:0]   gain,
    output ccn_pkg::scale_rsp_t                  rsp
);
    import ccn_pkg::*;

    localparam int PROD_BITS = COUNT_BITS + OUT_BITS;
    localparam int CNT_BITS  = $clog2(OUT_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR_PROD,
        S_RAW_PROD,
        S_DECIDE,
        S_DIVIDE
    } state_t;

    state_t                  state_reg,     state_next;
    logic [COUNT_BITS-1:0]   raw_reg,       raw_next;
    logic [COUNT_BITS-1:0]   clear_reg,     clear_next;
    logic [GAIN_BITS-1:0]    gain_reg,      gain_next;
    logic [PROD_BITS-1:0]    prod_reg,      prod_next;
    logic                    low_light_reg, low_light_next;
    logic [COUNT_BITS-1:0]   rem_reg,       rem_next;
    logic [OUT_BITS-1:0]     quot_reg,      quot_next;
    logic [CNT_BITS-1:0]     bit_cnt_reg,   bit_cnt_next;
    scale_rsp_t              rsp_reg,       rsp_next;

    logic [COUNT_BITS-1:0]   mul_a;
    logic [PROD_BITS-1:0]    product;
    logic [PROD_BITS-1:0]    dividend;
    logic [COUNT_BITS-1:0]   div_high;
    logic [OUT_BITS-1:0]     div_low;
    logic [COUNT_BITS:0]     trial;
    logic                    trial_ge;
    logic [OUT_BITS-1:0]     prod_sat;

    // The single multiplier serves clear*gain first, then raw*gain.
    assign mul_a    = (state_reg == S_CLEAR_PROD) ? clear_reg : raw_reg;
    assign product  = PROD_BITS'(mul_a) * PROD_BITS'(gain_reg);

    // raw*255 as a shift and subtract.
    assign dividend = (PROD_BITS'(raw_reg) << OUT_BITS) - PROD_BITS'(raw_reg);
    assign div_high = dividend[PROD_BITS-1:OUT_BITS];
    assign div_low  = dividend[OUT_BITS-1:0];

    assign trial    = {rem_reg, div_low[bit_cnt_reg]};
    assign trial_ge = (trial >= {1'b0, clear_reg});

    assign prod_sat = (prod_reg[PROD_BITS-1:OUT_BITS] != '0) ? SAT_MAX
                                                              : prod_reg[OUT_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        raw_next       = raw_reg;
        clear_next     = clear_reg;
        gain_next      = gain_reg;
        prod_next      = prod_reg;
        low_light_next = low_light_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        bit_cnt_next   = bit_cnt_reg;
        rsp_next       = rsp_reg;
        rsp_next.done  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    raw_next   = raw;
                    clear_next = clear;
                    gain_next  = gain;
                    state_next = S_CLEAR_PROD;
                end
            end
            S_CLEAR_PROD:
            begin
                prod_next  = product;
                state_next = S_RAW_PROD;
            end
            S_RAW_PROD:
            begin
                low_light_next = (prod_reg < PROD_BITS'(SAT_MAX));
                prod_next      = product;
                state_next     = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (low_light_reg)
                begin
                    rsp_next.done  = 1'b1;
                    rsp_next.value = prod_sat;
                    state_next     = S_IDLE;
                end
                else if (div_high >= clear_reg)
                begin
                    // Quotient would reach 256 or more: saturate.
                    rsp_next.done  = 1'b1;
                    rsp_next.value = SAT_MAX;
                    state_next     = S_IDLE;
                end
                else
                begin
                    rem_next     = div_high;
                    quot_next    = '0;
                    bit_cnt_next = CNT_BITS'(OUT_BITS - 1);
                    state_next   = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                rem_next     = trial_ge ? COUNT_BITS'(trial - {1'b0, clear_reg})
                                        : trial[COUNT_BITS-1:0];
                quot_next    = {quot_reg[OUT_BITS-2:0], trial_ge};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    rsp_next.done  = 1'b1;
                    rsp_next.value = {quot_reg[OUT_BITS-2:0], trial_ge};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            raw_reg       <= '0;
            clear_reg     <= '0;
            gain_reg      <= '0;
            prod_reg      <= '0;
            low_light_reg <= 1'b0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            bit_cnt_reg   <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            raw_reg       <= raw_next;
            clear_reg     <= clear_next;
            gain_reg      <= gain_next;
            prod_reg      <= prod_next;
            low_light_reg <= low_light_next;
            rem_reg       <= rem_next;
            quot_reg      <= quot_next;
            bit_cnt_reg   <= bit_cnt_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/color_channel_normalizer.sv
// Flow: a dark sample or a zero clear count goes from acceptance straight to the emit state;
// otherwise each of the three channels in turn passes through the shared scaling unit
// and its bit-serial divider before the word is emitted.
// Samples: one at a time; the next sample is taken only after the word of the last one
// is loaded, and loading waits as long as the output register holds an untaken word.
// Reset: rst_n is asynchronous, active low; it restores the register defaults and zero last colors.
// ----------------------------------------------------------------------------
// Color channel normalizer
// Turns a filtered red, green, blue and clear word into an 8-bit color word
// scaled to the clear count, with black-level removal, gain cap, saturation
// and outlier smoothing against the last delivered color.
// ----------------------------------------------------------------------------
`default_nettype none

module color_channel_normalizer #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    ccn_in_if.sink                                   in_word,
    ccn_out_if.source                                out_word,
    input  wire logic                                cfg_we,
    input  wire logic [ccn_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [ccn_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ccn_pkg::*;

    // Sequencer: accept a sample, run each channel through the scaling unit in turn
    // unless the sample is dark or its clear is zero, then hand the color word to the output register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_EMIT
    } state_t;

    cfg_t        cfg;
    scale_rsp_t  scale_rsp;

    state_t                 state_reg,     state_next;
    logic [CH_BITS-1:0]     ch_reg,        ch_next;
    logic [COUNT_BITS-1:0]  chan_reg       [NUM_CH];
    logic [COUNT_BITS-1:0]  chan_next      [NUM_CH];
    logic [COUNT_BITS-1:0]  clear_reg,     clear_next;
    logic [OUT_BITS-1:0]    last_reg       [NUM_CH];
    logic [OUT_BITS-1:0]    last_next      [NUM_CH];
    logic                   dark_reg,      dark_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]    out_red_reg,   out_red_next;
    logic [OUT_BITS-1:0]    out_green_reg, out_green_next;
    logic [OUT_BITS-1:0]    out_blue_reg,  out_blue_next;
    logic                   out_dark_reg,  out_dark_next;

    logic                   in_fire;
    logic [COUNT_BITS-1:0]  red_in, green_in, blue_in, clear_in;
    logic [RAW_BITS-1:0]    red_wide, green_wide, blue_wide, clear_wide;
    logic                   sample_dark;
    logic [OUT_BITS-1:0]    cur_val;
    logic [OUT_BITS-1:0]    last_val;
    logic [OUT_BITS-1:0]    jump;
    logic [OUT_BITS:0]      pair_sum;
    logic [OUT_BITS-1:0]    smoothed;

    ccn_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    ccn_scale_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scale_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_START),
        .raw   (chan_reg[ch_reg]),
        .clear (clear_reg),
        .gain  (cfg.max_gain),
        .rsp   (scale_rsp)
    );

    assign in_word.ready = (state_reg == S_IDLE);
    assign in_fire       = in_word.valid && in_word.ready;

    // Only the low COUNT_BITS bits of each count take part.
    assign red_in     = in_word.red_raw[COUNT_BITS-1:0];
    assign green_in   = in_word.green_raw[COUNT_BITS-1:0];
    assign blue_in    = in_word.blue_raw[COUNT_BITS-1:0];
    assign clear_in   = in_word.clear_raw[COUNT_BITS-1:0];
    assign red_wide   = RAW_BITS'(red_in);
    assign green_wide = RAW_BITS'(green_in);
    assign blue_wide  = RAW_BITS'(blue_in);
    assign clear_wide = RAW_BITS'(clear_in);

    assign sample_dark = (clear_wide < cfg.dark_threshold);

    // Outlier smoothing: a jump beyond the limit is replaced by the floor
    // average of the new and the last value.
    assign cur_val  = scale_rsp.value;
    assign last_val = last_reg[ch_reg];
    assign jump     = (cur_val > last_val) ? (cur_val - last_val) : (last_val - cur_val);
    assign pair_sum = {1'b0, cur_val} + {1'b0, last_val};
    assign smoothed = (jump > cfg.outlier_limit) ? pair_sum[OUT_BITS:1] : cur_val;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        chan_next      = chan_reg;
        clear_next     = clear_reg;
        last_next      = last_reg;
        dark_next      = dark_reg;
        out_valid_next = out_valid_reg;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        out_dark_next  = out_dark_reg;

        if (out_valid_reg && out_word.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    // Black offsets are removed here, saturating at zero.
                    chan_next[0] = (red_wide > cfg.black_red_offset)
                                   ? COUNT_BITS'(red_wide - cfg.black_red_offset) : '0;
                    chan_next[1] = (green_wide > cfg.black_green_offset)
                                   ? COUNT_BITS'(green_wide - cfg.black_green_offset) : '0;
                    chan_next[2] = (blue_wide > cfg.black_blue_offset)
                                   ? COUNT_BITS'(blue_wide - cfg.black_blue_offset) : '0;
                    clear_next   = clear_in;
                    ch_next      = CH_FIRST;
                    dark_next    = sample_dark;
                    if (sample_dark)
                    begin
                        // Forced black also clears the kept colors.
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            last_next[i] = '0;
                        end
                        state_next = S_EMIT;
                    end
                    else if (clear_in == '0)
                    begin
                        // A zero clear count repeats the last color unchanged.
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (scale_rsp.done)
                begin
                    last_next[ch_reg] = smoothed;
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_START;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_word.ready)
                begin
                    // The is_dark flag is loaded together with the word it describes.
                    out_valid_next = 1'b1;
                    out_red_next   = last_reg[0];
                    out_green_next = last_reg[1];
                    out_blue_next  = last_reg[2];
                    out_dark_next  = dark_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= CH_FIRST;
            clear_reg     <= '0;
            dark_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            out_dark_reg  <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                chan_reg[i] <= '0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            clear_reg     <= clear_next;
            dark_reg      <= dark_next;
            out_valid_reg <= out_valid_next;
            out_red_reg   <= out_red_next;
            out_green_reg <= out_green_next;
            out_blue_reg  <= out_blue_next;
            out_dark_reg  <= out_dark_next;
            chan_reg      <= chan_next;
            last_reg      <= last_next;
        end
    end

    assign out_word.valid     = out_valid_reg;
    assign out_word.red_out   = out_red_reg;
    assign out_word.green_out = out_green_reg;
    assign out_word.blue_out  = out_blue_reg;
    assign out_word.is_dark   = out_dark_reg;

    // An accepted sample always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != S_IDLE)
        else $error("sequencer stayed idle after accepting a sample");

    // The scaling unit only answers while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        scale_rsp.done |-> state_reg == S_WAIT)
        else $error("scaling result arrived outside the wait state");

    // A dark word carries a black color.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_word.valid && out_word.is_dark) |->
            (out_word.red_out == '0 && out_word.green_out == '0 && out_word.blue_out == '0))
        else $error("dark word with a nonzero color");

endmodule

`default_nettype wire

FILE: tb/tb_color_channel_normalizer.sv
// ----------------------------------------------------------------------------
// Color channel normalizer testbench
// Feeds raw red, green, blue and clear words into the normalizer under a
// series of register settings and compares every color word it delivers
// with a built-in predictor that tracks the kept last colors and the
// register values on its own side. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_color_channel_normalizer;

    timeunit 1ns;
    timeprecision 1ps;

    import ccn_pkg::*;

    // Register indexes past the last defined register; writes to them must
    // leave every register as it was.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

    // Even with both sides stalling, a run of some 500 words through the block
    // stays far below this bound.
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 50;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned STALL_PERCENT = 26;

    typedef struct packed {
        logic [RAW_BITS-1:0] red;
        logic [RAW_BITS-1:0] green;
        logic [RAW_BITS-1:0] blue;
        logic [RAW_BITS-1:0] clear;
    } raw_sample_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] red;
        logic [OUT_BITS-1:0] green;
        logic [OUT_BITS-1:0] blue;
        logic                dark;
    } color_word_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    ccn_in_if  in_word();
    ccn_out_if out_word();

    color_channel_normalizer #(
        .COUNT_BITS (RAW_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Raw words waiting to be sent, and the color words the block still owes.
    raw_sample_t raw_backlog[$];
    color_word_t pending_colors[$];

    // Predictor state: our own copy of the registers and of the last colors.
    cfg_t                model_cfg;
    logic [OUT_BITS-1:0] kept_red;
    logic [OUT_BITS-1:0] kept_green;
    logic [OUT_BITS-1:0] kept_blue;

    int unsigned fail_count;
    int unsigned cycle_count;

    // While calm is set neither side stalls, which gives the block a long
    // stretch of back-to-back words.
    logic calm;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Scale one offset-corrected channel to the clear count. In low light the
    // fixed maximum gain is used; otherwise the exact floor of raw*255/clear.
    function automatic logic [OUT_BITS-1:0] gain_scale(int unsigned raw,
                                                       int unsigned clear);
        int unsigned level;
        if (clear * model_cfg.max_gain < 32'd255)
            level = raw * model_cfg.max_gain;
        else
            level = (raw * 32'd255) / clear;
        return (level > 32'd255) ? SAT_MAX : level[OUT_BITS-1:0];
    endfunction

    // A jump larger than the outlier limit is pulled halfway back.
    function automatic logic [OUT_BITS-1:0] damp_jump(logic [OUT_BITS-1:0] fresh,
                                                      logic [OUT_BITS-1:0] last);
        int unsigned jump;
        int unsigned blend;
        jump = (fresh > last) ? fresh - last : last - fresh;
        if (jump > model_cfg.outlier_limit)
        begin
            blend = (int'(fresh) + int'(last)) >> 1;
            return blend[OUT_BITS-1:0];
        end
        return fresh;
    endfunction

    function automatic int unsigned strip_black(logic [RAW_BITS-1:0] raw,
                                                logic [RAW_BITS-1:0] black);
        return (raw > black) ? raw - black : 0;
    endfunction

    // Works out the color word for one raw word and advances the kept colors.
    function automatic color_word_t normalize_sample(raw_sample_t s);
        color_word_t res;
        if (s.clear < model_cfg.dark_threshold)
        begin
            kept_red   = '0;
            kept_green = '0;
            kept_blue  = '0;
            res = '{red: '0, green: '0, blue: '0, dark: 1'b1};
            return res;
        end
        // A clear count of zero leaves the kept colors untouched.
        if (s.clear != '0)
        begin
            kept_red = damp_jump(gain_scale(strip_black(s.red, model_cfg.black_red_offset),
                                            s.clear), kept_red);
            kept_green = damp_jump(gain_scale(strip_black(s.green,
                                                          model_cfg.black_green_offset),
                                              s.clear), kept_green);
            kept_blue = damp_jump(gain_scale(strip_black(s.blue, model_cfg.black_blue_offset),
                                             s.clear), kept_blue);
        end
        res = '{red: kept_red, green: kept_green, blue: kept_blue, dark: 1'b0};
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: sends the backlog one word at a time. The expected color word is
    // worked out at the edge where the block takes the word.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : raw_driver
        raw_sample_t upcoming;
        if (!rst_n)
        begin
            in_word.valid     <= 1'b0;
            in_word.red_raw   <= '0;
            in_word.green_raw <= '0;
            in_word.blue_raw  <= '0;
            in_word.clear_raw <= '0;
        end
        else
        begin
            if (in_word.valid && in_word.ready)
                pending_colors.push_back(normalize_sample('{red:   in_word.red_raw,
                                                            green: in_word.green_raw,
                                                            blue:  in_word.blue_raw,
                                                            clear: in_word.clear_raw}));
            if (!in_word.valid || in_word.ready)
            begin
                if (raw_backlog.size() != 0
                    && (calm || $urandom_range(99) >= STALL_PERCENT))
                begin
                    upcoming = raw_backlog.pop_front();
                    in_word.valid     <= 1'b1;
                    in_word.red_raw   <= upcoming.red;
                    in_word.green_raw <= upcoming.green;
                    in_word.blue_raw  <= upcoming.blue;
                    in_word.clear_raw <= upcoming.clear;
                end
                else
                begin
                    in_word.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every color word taken from the block is checked against the
    // oldest expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : color_monitor
        color_word_t seen;
        color_word_t want;
        if (!rst_n)
        begin
            out_word.ready <= 1'b0;
        end
        else
        begin
            if (out_word.valid && out_word.ready)
            begin
                seen = '{red:   out_word.red_out,
                         green: out_word.green_out,
                         blue:  out_word.blue_out,
                         dark:  out_word.is_dark};
                if (pending_colors.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected color word r=%0d g=%0d b=%0d dark=%0b",
                                 seen.red, seen.green, seen.blue, seen.dark);
                end
                else
                begin
                    want = pending_colors.pop_front();
                    if (seen.red !== want.red || seen.green !== want.green
                        || seen.blue !== want.blue || seen.dark !== want.dark)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("color mismatch: expected r=%0d g=%0d b=%0d dark=%0b, %s",
                                     want.red, want.green, want.blue, want.dark,
                                     $sformatf("got r=%0d g=%0d b=%0d dark=%0b",
                                               seen.red, seen.green, seen.blue,
                                               seen.dark));
                    end
                end
            end
            out_word.ready <= calm || ($urandom_range(99) >= STALL_PERCENT);
        end
    end

    // A hung block must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One register write per clock; the caller lowers the write enable after
    // the last write of a batch, so the enable is assigned once per step.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index,
                             logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_DARK_THRESHOLD: model_cfg.dark_threshold     = data;
            REG_BLACK_RED:      model_cfg.black_red_offset   = data;
            REG_BLACK_GREEN:    model_cfg.black_green_offset = data;
            REG_BLACK_BLUE:     model_cfg.black_blue_offset  = data;
            REG_MAX_GAIN:       model_cfg.max_gain           = data[GAIN_BITS-1:0];
            REG_OUTLIER_LIMIT:  model_cfg.outlier_limit      = data[LIMIT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_sample(int unsigned red, int unsigned green,
                                int unsigned blue, int unsigned clear);
        raw_backlog.push_back('{red: red[RAW_BITS-1:0], green: green[RAW_BITS-1:0],
                                blue: blue[RAW_BITS-1:0], clear: clear[RAW_BITS-1:0]});
    endtask

    // Waits until every word has gone through and come back, then a few more
    // cycles, so that registers are only touched while the block is idle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (raw_backlog.size() != 0 || in_word.valid || pending_colors.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Color counts are mostly placed near clear*k/255 above the black level,
    // so that the scaled values land across the whole 8-bit range.
    function automatic int unsigned pick_channel(int unsigned clear,
                                                 logic [RAW_BITS-1:0] black);
        int unsigned count;
        case ($urandom_range(4))
            0: count = $urandom_range(65535);
            1: count = $urandom_range(300);
            default: count = black + clear * $urandom_range(280) / 255;
        endcase
        return (count > 65535) ? 65535 : count;
    endfunction

    task automatic queue_random(int unsigned words);
        int unsigned clear;
        int unsigned thr;
        repeat (words)
        begin
            thr = model_cfg.dark_threshold;
            case ($urandom_range(9))
                0: clear = 0;
                1: clear = (thr > 0) ? $urandom_range(thr - 1) : 0;
                2: clear = $urandom_range(300);
                3: clear = 65535;
                default: clear = $urandom_range(65535, thr);
            endcase
            queue_sample(pick_channel(clear, model_cfg.black_red_offset),
                         pick_channel(clear, model_cfg.black_green_offset),
                         pick_channel(clear, model_cfg.black_blue_offset),
                         clear);
        end
    endtask

    function automatic int unsigned pick_black();
        case ($urandom_range(5))
            0, 1: return 0;
            2, 3: return $urandom_range(500);
            4: return $urandom_range(65535);
            default: return 65535;
        endcase
    endfunction

    // A fresh random setting of all six registers. The gain and outlier
    // writes carry random upper bits that the block must drop.
    task automatic random_settings();
        int unsigned thr;
        int unsigned gain;
        logic [7:0]  junk;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: thr = 0;
            5, 6: thr = $urandom_range(2000);
            7: thr = $urandom_range(65535);
            8: thr = 65535;
            default: thr = $urandom_range(100);
        endcase
        case ($urandom_range(5))
            0: gain = 1;
            1: gain = 255;
            default: gain = $urandom_range(255, 1);
        endcase
        write_reg(REG_DARK_THRESHOLD, thr[CFG_DATA_BITS-1:0]);
        write_reg(REG_BLACK_RED, CFG_DATA_BITS'(pick_black()));
        write_reg(REG_BLACK_GREEN, CFG_DATA_BITS'(pick_black()));
        write_reg(REG_BLACK_BLUE, CFG_DATA_BITS'(pick_black()));
        junk = 8'($urandom_range(255));
        write_reg(REG_MAX_GAIN, {junk, gain[7:0]});
        junk = 8'($urandom_range(255));
        write_reg(REG_OUTLIER_LIMIT, {junk, 8'($urandom_range(255))});
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_DATA_BITS'($urandom_range(65535)));
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        int unsigned waited;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_word.valid  = 1'b0;
        in_word.red_raw   = '0;
        in_word.green_raw = '0;
        in_word.blue_raw  = '0;
        in_word.clear_raw = '0;
        out_word.ready = 1'b0;
        calm           = 1'b0;
        fail_count     = 0;
        cycle_count    = 0;

        model_cfg = '{dark_threshold:     '0,
                      black_red_offset:   '0,
                      black_green_offset: '0,
                      black_blue_offset:  '0,
                      max_gain:           MAX_GAIN_RESET,
                      outlier_limit:      OUTLIER_RESET};
        kept_red   = '0;
        kept_green = '0;
        kept_blue  = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: threshold 0, no black level, gain 10, limit 30.
        // Zero clear first, with and without color, which must repeat the
        // kept colors; then full scale, which the outlier filter halves.
        queue_sample(0, 0, 0, 0);
        queue_sample(65535, 65535, 65535, 0);
        queue_sample(65535, 65535, 65535, 65535);
        queue_sample(65535, 65535, 65535, 65535);
        queue_sample(0, 0, 0, 65535);
        // Low light right below and right at the gain cap.
        queue_sample(5, 25, 0, 25);
        queue_sample(1, 26, 3, 26);
        queue_sample(0, 0, 0, 0);
        // Divisions that come out exact, where a float would truncate low.
        queue_sample(765, 510, 1, 765);
        queue_sample(300, 600, 900, 900);
        wait_idle();

        // Highest threshold and black levels, gain of zero via the masked
        // upper byte, no outlier tolerance, and writes to unused indexes.
        write_reg(REG_DARK_THRESHOLD, 16'hFFFF);
        write_reg(REG_BLACK_RED, 16'hFFFF);
        write_reg(REG_BLACK_GREEN, 16'hFFFF);
        write_reg(REG_BLACK_BLUE, 16'hFFFF);
        write_reg(REG_MAX_GAIN, 16'hFF00);
        write_reg(REG_OUTLIER_LIMIT, 16'h0000);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0001);
        cfg_we <= 1'b0;
        queue_sample(65535, 65535, 65535, 65534);
        queue_sample(65535, 65535, 65535, 65535);
        queue_sample(0, 0, 0, 0);
        wait_idle();

        // Threshold one, full gain, widest outlier tolerance.
        write_reg(REG_DARK_THRESHOLD, 16'd1);
        write_reg(REG_BLACK_RED, 16'd0);
        write_reg(REG_BLACK_GREEN, 16'd0);
        write_reg(REG_BLACK_BLUE, 16'd0);
        write_reg(REG_MAX_GAIN, 16'd255);
        write_reg(REG_OUTLIER_LIMIT, 16'd255);
        cfg_we <= 1'b0;
        queue_sample(0, 0, 0, 0);
        queue_sample(1, 1, 1, 1);
        queue_sample(65535, 0, 32768, 65535);
        queue_sample(300, 600, 1, 1);
        wait_idle();

        // Gain of one, where clear 254 is low light and 255 is not, with
        // distinct black levels per channel.
        write_reg(REG_DARK_THRESHOLD, 16'd0);
        write_reg(REG_BLACK_RED, 16'd100);
        write_reg(REG_BLACK_GREEN, 16'd200);
        write_reg(REG_BLACK_BLUE, 16'd300);
        write_reg(REG_MAX_GAIN, 16'd1);
        write_reg(REG_OUTLIER_LIMIT, 16'd0);
        cfg_we <= 1'b0;
        queue_sample(100, 199, 65535, 254);
        queue_sample(356, 455, 556, 255);
        queue_sample(0, 0, 0, 0);
        queue_sample(65535, 65535, 65535, 65535);
        wait_idle();

        // Random settings with random words. One phase runs with no stalls
        // at all on either side.
        for (int phase = 0; phase < 8; phase++)
        begin
            random_settings();
            calm = (phase == 4);
            queue_random(calm ? 110 : 55);
            wait_idle();
        end
        calm = 1'b0;

        waited = 0;
        while ((raw_backlog.size() != 0 || in_word.valid || pending_colors.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_colors.size() != 0)
        begin
            $display("%0d color words never arrived", pending_colors.size());
            fail_count += pending_colors.size();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
